@@ rtl/core/mvbr_pkg.sv @@
// Shared types, codes and default sizes for the matrix vector bias ReLU engine.
`timescale 1ns / 1ps

package mvbr_pkg;

  localparam int MVBR_MAX_IN_CHANNELS  = 512;
  localparam int MVBR_MAX_OUT_CHANNELS = 512;
  localparam int MVBR_DATA_WIDTH       = 16;

  localparam int OP_W       = 2;
  localparam int CHAN_W     = 9;
  localparam int VALUE_W    = 16;
  localparam int RESULT_W   = 16;
  localparam int CFG_CH_W   = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int ACC_W      = 48;
  localparam int ACC_FRAC   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_CHANNELS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELU_ENABLE = 1'd1;

  localparam logic [CFG_CH_W-1:0] IN_CHANNELS_RESET = 10'd24;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_WEIGHT = 2'd0,
    OP_WRITE_BIAS   = 2'd1,
    OP_LOAD_ACT     = 2'd2,
    OP_COMPUTE      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_RUN,
    ST_FINISH,
    ST_DONE
  } state_e;

endpackage

@@ rtl/core/matrix_vector_bias_relu.sv @@
// Top level of the pointwise convolution engine with bias and optional ReLU.
//
// The input channel carries items of four kinds: weight write, bias write,
// activation load and compute. Writes and loads are accepted back to back and
// give no result. A compute item for an output channel walks the stored
// activations and the weight row of that channel through one shared
// multiplier and one 48-bit accumulator, one input channel per cycle.
// A compute item loads the bias, then issues reads for n input channels, where
// n is in_channels clamped to MAX_IN_CHANNELS, lets the read and product
// registers drain, and then applies ReLU, shifts and saturates the accumulator
// into the result. Input ready is low while a compute item is in progress, so a
// new item is taken only after the last result has moved to the output register.
// A compute item for an out of range channel skips the loop and gives a zero result.
// The result sits in an output register; a stalled receiver holds it there
// while writes and loads are still accepted, and a following compute item
// waits before that register only once its own result is ready.
// Reset clears the sequencer, the output valid flag and the configuration
// registers (in_channels 24, ReLU enabled). The memories are not cleared and
// must be written before they are read. Configuration must be written only while
// the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps

module matrix_vector_bias_relu
  import mvbr_pkg::*;
#(
  parameter int MAX_IN_CHANNELS  = MVBR_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = MVBR_MAX_OUT_CHANNELS,
  parameter int DATA_WIDTH       = MVBR_DATA_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [OP_W-1:0]            operation_i,
  input  logic [CHAN_W-1:0]          out_channel_i,
  input  logic [CHAN_W-1:0]          in_channel_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [CHAN_W-1:0]          channel_index_o,
  output logic signed [RESULT_W-1:0] result_o,
  output logic                       saturated_o
);

  localparam int AIW    = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
  localparam int BIW    = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
  localparam int WDEPTH = MAX_IN_CHANNELS * MAX_OUT_CHANNELS;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int NW     = ($clog2(MAX_IN_CHANNELS + 1) > CFG_CH_W) ?
                          $clog2(MAX_IN_CHANNELS + 1) : CFG_CH_W;
  localparam int VW     = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int PW     = 2 * DATA_WIDTH;
  localparam int RW     = ACC_W - ACC_FRAC;

  localparam logic signed [RW-1:0] SAT_HI =
    RW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (DATA_WIDTH - 1)));

  state_e state_q, state_d;

  logic [CFG_CH_W-1:0] in_channels_q;
  logic                relu_q;

  logic signed [DATA_WIDTH-1:0] weight_mem [WDEPTH];
  logic signed [DATA_WIDTH-1:0] bias_mem   [MAX_OUT_CHANNELS];
  logic signed [DATA_WIDTH-1:0] act_mem    [MAX_IN_CHANNELS];

  logic signed [DATA_WIDTH-1:0] w_rd_q, a_rd_q, b_rd_q;
  logic signed [DATA_WIDTH-1:0] v_ext;
  logic signed [PW-1:0]         prod_q;
  logic signed [ACC_W-1:0]      acc_q, acc_relu;
  logic signed [RW-1:0]         r_shift, r_sat;
  logic                         r_over;

  logic [NW-1:0]     cnt_q, n_q, n_clamp;
  logic [WAW-1:0]    waddr_q;
  logic [CHAN_W-1:0] chan_q;
  logic [RESULT_W-1:0] res_q;
  logic              res_sat_q;
  logic              rd_vld_q, prod_vld_q;

  logic in_acc, co_ok, ci_ok, is_compute;
  logic start_run, start_skip, load_bias, issue, finish, out_load;

  assign in_acc     = in_valid_i && in_ready_o;
  assign co_ok      = 32'(out_channel_i) < MAX_OUT_CHANNELS;
  assign ci_ok      = 32'(in_channel_i) < MAX_IN_CHANNELS;
  assign is_compute = op_e'(operation_i) == OP_COMPUTE;
  assign v_ext      = DATA_WIDTH'(signed'(value_i[VW-1:0]));
  assign n_clamp    = (NW'(in_channels_q) > NW'(MAX_IN_CHANNELS)) ?
                      NW'(MAX_IN_CHANNELS) : NW'(in_channels_q);

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    start_run  = 1'b0;
    start_skip = 1'b0;
    load_bias  = 1'b0;
    issue      = 1'b0;
    finish     = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && is_compute) begin
          if (co_ok) begin
            start_run = 1'b1;
            state_d   = ST_BIAS;
          end else begin
            start_skip = 1'b1;
            state_d    = ST_DONE;
          end
        end
      end
      ST_BIAS: begin
        load_bias = 1'b1;
        state_d   = ST_RUN;
      end
      ST_RUN: begin
        if (cnt_q < n_q) begin
          issue = 1'b1;
        end else if (!rd_vld_q && !prod_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish  = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      in_channels_q <= IN_CHANNELS_RESET;
      relu_q        <= 1'b1;
      rd_vld_q      <= 1'b0;
      prod_vld_q    <= 1'b0;
      out_valid_o   <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_IN_CHANNELS: in_channels_q <= cfg_data_i[CFG_CH_W-1:0];
          CFG_RELU_ENABLE: relu_q        <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && co_ok && ci_ok && op_e'(operation_i) == OP_WRITE_WEIGHT) begin
      weight_mem[WAW'(WAW'(out_channel_i) * WAW'(MAX_IN_CHANNELS) + WAW'(in_channel_i))]
        <= v_ext;
    end
    w_rd_q <= weight_mem[waddr_q];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && co_ok && op_e'(operation_i) == OP_WRITE_BIAS) begin
      bias_mem[out_channel_i[BIW-1:0]] <= v_ext;
    end
    if (in_acc) begin
      b_rd_q <= bias_mem[out_channel_i[BIW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ci_ok && op_e'(operation_i) == OP_LOAD_ACT) begin
      act_mem[in_channel_i[AIW-1:0]] <= v_ext;
    end
    a_rd_q <= act_mem[cnt_q[AIW-1:0]];
  end

  assign acc_relu = (relu_q && acc_q[ACC_W-1]) ? '0 : acc_q;
  assign r_shift  = RW'(acc_relu >>> ACC_FRAC);
  assign r_over   = (r_shift > SAT_HI) || (r_shift < SAT_LO);
  assign r_sat    = (r_shift > SAT_HI) ? SAT_HI :
                    (r_shift < SAT_LO) ? SAT_LO : r_shift;

  always_ff @(posedge clk_i) begin
    if (start_run || start_skip) begin
      chan_q  <= out_channel_i;
      n_q     <= n_clamp;
      cnt_q   <= '0;
      waddr_q <= WAW'(WAW'(out_channel_i) * WAW'(MAX_IN_CHANNELS));
    end else if (issue) begin
      cnt_q   <= cnt_q + 1'b1;
      waddr_q <= waddr_q + 1'b1;
    end
    if (rd_vld_q) begin
      prod_q <= w_rd_q * a_rd_q;
    end
    if (load_bias) begin
      acc_q <= ACC_W'(b_rd_q) <<< ACC_FRAC;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (start_skip) begin
      res_q     <= '0;
      res_sat_q <= 1'b0;
    end else if (finish) begin
      res_q     <= RESULT_W'(r_sat);
      res_sat_q <= r_over;
    end
    if (out_load) begin
      channel_index_o <= chan_q;
      result_o        <= res_q;
      saturated_o     <= res_sat_q;
    end
  end

endmodule

@@ rtl/core/mvbr_checker.sv @@
// Port-level checker for the matrix vector bias ReLU engine and its bind.
`timescale 1ns / 1ps

module mvbr_checker
  import mvbr_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic [OP_W-1:0]            operation_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [CHAN_W-1:0]          channel_index_o,
  input logic signed [RESULT_W-1:0] result_o,
  input logic                       saturated_o
);

  property p_out_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=>
        out_valid_o && $stable(channel_index_o) && $stable(result_o) &&
        $stable(saturated_o);
  endproperty

  property p_compute_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && op_e'(operation_i) == OP_COMPUTE |=> !in_ready_o;
  endproperty

  property p_write_stays_ready;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && op_e'(operation_i) != OP_COMPUTE |=> in_ready_o;
  endproperty

  property p_compute_no_early_result;
    @(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o && op_e'(operation_i) == OP_COMPUTE && out_ready_i
        |=> !out_valid_o;
  endproperty

  a_out_hold: assert property (p_out_hold)
    else $error("stalled result item changed or dropped");
  a_compute_busy: assert property (p_compute_busy)
    else $error("input ready while a compute item is in progress");
  a_write_stays_ready: assert property (p_write_stays_ready)
    else $error("ready dropped after a write item");
  a_compute_no_early_result: assert property (p_compute_no_early_result)
    else $error("result item appeared in the cycle after a compute item");

endmodule

bind matrix_vector_bias_relu mvbr_checker u_mvbr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .operation_i     (operation_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .channel_index_o (channel_index_o),
  .result_o        (result_o),
  .saturated_o     (saturated_o)
);

@@ sim/mvbr_result_checker.sv @@
// Result checker that predicts and compares every output item of the engine.
`timescale 1ns / 1ps

module mvbr_result_checker
  import mvbr_pkg::*;
#(
  parameter int MAX_IN_CHANNELS  = MVBR_MAX_IN_CHANNELS,
  parameter int MAX_OUT_CHANNELS = MVBR_MAX_OUT_CHANNELS,
  parameter int DATA_WIDTH       = MVBR_DATA_WIDTH
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [OP_W-1:0]            operation_i,
  input  logic [CHAN_W-1:0]          out_channel_i,
  input  logic [CHAN_W-1:0]          in_channel_i,
  input  logic signed [VALUE_W-1:0]  value_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [CHAN_W-1:0]          channel_index_i,
  input  logic signed [RESULT_W-1:0] result_i,
  input  logic                       saturated_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  typedef struct packed {
    logic [CHAN_W-1:0]          chan;
    logic signed [RESULT_W-1:0] value;
    logic                       sat;
  } channel_result_t;

  logic signed [VALUE_W-1:0] weight_mem [MAX_OUT_CHANNELS*MAX_IN_CHANNELS];
  logic signed [VALUE_W-1:0] bias_mem   [MAX_OUT_CHANNELS];
  logic signed [VALUE_W-1:0] act_mem    [MAX_IN_CHANNELS];

  logic [CFG_CH_W-1:0] in_channels_q = IN_CHANNELS_RESET;
  logic                relu_q        = 1'b1;

  channel_result_t expected_results[$];
  int              mismatches = 0;

  function automatic channel_result_t mac_bias_relu(input logic [CHAN_W-1:0] co);
    channel_result_t           res;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   scaled;
    longint                    prod;
    longint                    hi_lim;
    longint                    lo_lim;
    int                        n;
    res.chan  = co;
    res.value = '0;
    res.sat   = 1'b0;
    if (int'(co) >= MAX_OUT_CHANNELS) return res;
    hi_lim = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
    lo_lim = -hi_lim - 1;
    n = (int'(in_channels_q) > MAX_IN_CHANNELS) ? MAX_IN_CHANNELS : int'(in_channels_q);
    acc = bias_mem[co];
    acc = acc <<< ACC_FRAC;
    for (int i = 0; i < n; i++) begin
      prod = longint'(weight_mem[int'(co) * MAX_IN_CHANNELS + i]) * longint'(act_mem[i]);
      acc = acc + prod[ACC_W-1:0];
    end
    if (relu_q && acc < 0) acc = '0;
    scaled = acc >>> ACC_FRAC;
    if (scaled > hi_lim) begin
      res.value = hi_lim[RESULT_W-1:0];
      res.sat   = 1'b1;
    end else if (scaled < lo_lim) begin
      res.value = lo_lim[RESULT_W-1:0];
      res.sat   = 1'b1;
    end else begin
      res.value = scaled[RESULT_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    channel_result_t got;
    channel_result_t want;
    if (!rst_ni) begin
      in_channels_q = IN_CHANNELS_RESET;
      relu_q        = 1'b1;
      expected_results.delete();
      pending_o     <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got.chan  = channel_index_i;
        got.value = result_i;
        got.sat   = saturated_i;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got ch %0d value %0d sat %0b",
                   $time, got.chan, $signed(got.value), got.sat);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            $display({"%0t: result mismatch, expected ch %0d value %0d sat %0b, ",
                      "got ch %0d value %0d sat %0b"},
                     $time, want.chan, $signed(want.value), want.sat,
                     got.chan, $signed(got.value), got.sat);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IN_CHANNELS: in_channels_q = cfg_data_i[CFG_CH_W-1:0];
          CFG_RELU_ENABLE: relu_q = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        case (operation_i)
          OP_WRITE_WEIGHT: begin
            if (int'(out_channel_i) < MAX_OUT_CHANNELS &&
                int'(in_channel_i) < MAX_IN_CHANNELS)
              weight_mem[int'(out_channel_i) * MAX_IN_CHANNELS + int'(in_channel_i)] =
                value_i;
          end
          OP_WRITE_BIAS: begin
            if (int'(out_channel_i) < MAX_OUT_CHANNELS) bias_mem[out_channel_i] = value_i;
          end
          OP_LOAD_ACT: begin
            if (int'(in_channel_i) < MAX_IN_CHANNELS) act_mem[in_channel_i] = value_i;
          end
          OP_COMPUTE: expected_results.push_back(mac_bias_relu(out_channel_i));
          default: ;
        endcase
      end
      pending_o <= expected_results.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

@@ sim/tb_matrix_vector_bias_relu.sv @@
// Testbench top that drives stimulus into the engine and reports the verdict.
`timescale 1ns / 1ps

module tb_matrix_vector_bias_relu;
  import mvbr_pkg::*;

  localparam int MAX_IN      = MVBR_MAX_IN_CHANNELS;
  localparam int MAX_OUT     = MVBR_MAX_OUT_CHANNELS;
  localparam int STALL_LIMIT = 8000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = MAX_IN + 16;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i    = '0;
  logic                       in_valid_i    = 1'b0;
  logic [OP_W-1:0]            operation_i   = '0;
  logic [CHAN_W-1:0]          out_channel_i = '0;
  logic [CHAN_W-1:0]          in_channel_i  = '0;
  logic signed [VALUE_W-1:0]  value_i       = '0;
  logic                       out_ready_i   = 1'b0;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic [CHAN_W-1:0]          channel_index_o;
  logic signed [RESULT_W-1:0] result_o;
  logic                       saturated_o;
  int                         fail_count;
  int                         pending;

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  holds_asked    = 0;
  int  idle_cycles    = 0;
  int  cur_channels   = IN_CHANNELS_RESET;

  bit  weight_written [MAX_OUT*MAX_IN];
  bit  bias_written   [MAX_OUT];
  bit  act_written    [MAX_IN];
  logic [CHAN_W-1:0] hot_channels [4];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix_vector_bias_relu DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .out_channel_i  (out_channel_i),
    .in_channel_i   (in_channel_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_index_o(channel_index_o),
    .result_o       (result_o),
    .saturated_o    (saturated_o)
  );

  mvbr_result_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .out_channel_i  (out_channel_i),
    .in_channel_i   (in_channel_i),
    .value_i        (value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .channel_index_i(channel_index_o),
    .result_i       (result_o),
    .saturated_i    (saturated_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // The receiver honors long hold-off requests before returning to random stalls.
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (holds_asked != holds_done) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** matrix_vector_bias_relu: FAILED **");
      $finish;
    end
  end

  function automatic int active_channels();
    return (cur_channels > MAX_IN) ? MAX_IN : cur_channels;
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return VALUE_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      2: return VALUE_W'(int'($urandom_range(511)) - 256);
      default: return VALUE_W'(int'($urandom_range(4095)) - 2048);
    endcase
  endfunction

  task automatic send_item(input op_e op, input logic [CHAN_W-1:0] co,
                           input logic [CHAN_W-1:0] ci, input logic [VALUE_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    out_channel_i <= co;
    in_channel_i  <= ci;
    value_i       <= val;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_write(input op_e op, input logic [CHAN_W-1:0] co,
                            input logic [CHAN_W-1:0] ci, input logic [VALUE_W-1:0] val);
    send_item(op, co, ci, val);
    case (op)
      OP_WRITE_WEIGHT: weight_written[int'(co) * MAX_IN + int'(ci)] = 1'b1;
      OP_WRITE_BIAS:   bias_written[co] = 1'b1;
      OP_LOAD_ACT:     act_written[ci] = 1'b1;
      default: ;
    endcase
  endtask

  // Fills in whatever the channel would read that was never written, then computes.
  task automatic send_compute(input logic [CHAN_W-1:0] co);
    int n;
    n = active_channels();
    for (int i = 0; i < n; i++)
      if (!act_written[i])
        send_write(OP_LOAD_ACT, CHAN_W'($urandom), CHAN_W'(i), rand_value());
    for (int i = 0; i < n; i++)
      if (!weight_written[int'(co) * MAX_IN + i])
        send_write(OP_WRITE_WEIGHT, co, CHAN_W'(i), rand_value());
    if (!bias_written[co])
      send_write(OP_WRITE_BIAS, co, CHAN_W'($urandom), rand_value());
    send_item(OP_COMPUTE, co, CHAN_W'($urandom), VALUE_W'($urandom));
  endtask

  task automatic start_phase(input int channels, input bit relu,
                             input int send_pct, input int recv_pct);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (active_channels() + 8) @(posedge clk_i);
    send_idle_pct  <= send_pct;
    recv_stall_pct <= recv_pct;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IN_CHANNELS;
    cfg_data_i  <= CFG_DATA_W'(channels);
    @(posedge clk_i);
    cfg_index_i <= CFG_RELU_ENABLE;
    cfg_data_i  <= CFG_DATA_W'(relu);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_channels = channels;
  endtask

  task automatic run_random(input int items, input int hot_cnt, input bit new_hot);
    int r;
    int span;
    logic [CHAN_W-1:0] co;
    if (new_hot)
      for (int k = 0; k < 4; k++) hot_channels[k] = CHAN_W'($urandom_range(MAX_OUT - 1));
    span = (active_channels() > 0) ? active_channels() : 1;
    for (int k = 0; k < items; k++) begin
      co = hot_channels[$urandom_range(hot_cnt - 1)];
      r  = $urandom_range(99);
      if (r < 35)
        send_write(OP_WRITE_WEIGHT, co, CHAN_W'($urandom_range(span - 1)), rand_value());
      else if (r < 45)
        send_write(OP_WRITE_BIAS, co, CHAN_W'($urandom), rand_value());
      else if (r < 60)
        send_write(OP_LOAD_ACT, CHAN_W'($urandom), CHAN_W'($urandom_range(span - 1)),
                   rand_value());
      else if (r < 70)
        send_write(op_e'($urandom_range(2)), CHAN_W'($urandom), CHAN_W'($urandom),
                   rand_value());
      else
        send_compute(co);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    start_phase(1, 1'b0, 0, 0);
    send_write(OP_LOAD_ACT, 9'd511, 9'd0, 16'h7FFF);
    send_write(OP_WRITE_WEIGHT, 9'd0, 9'd0, 16'h7FFF);
    send_write(OP_WRITE_BIAS, 9'd0, 9'd0, 16'h7FFF);
    send_compute(9'd0);
    send_write(OP_WRITE_WEIGHT, 9'd1, 9'd0, 16'h8000);
    send_write(OP_WRITE_BIAS, 9'd1, 9'd511, 16'h8000);
    send_compute(9'd1);
    send_write(OP_WRITE_WEIGHT, 9'd511, 9'd0, 16'h0001);
    send_write(OP_WRITE_WEIGHT, 9'd511, 9'd511, 16'hFFFF);
    send_write(OP_WRITE_BIAS, 9'd511, 9'd0, 16'h0000);
    send_write(OP_LOAD_ACT, 9'd0, 9'd511, 16'h8000);
    send_compute(9'd511);
    send_write(OP_LOAD_ACT, 9'd0, 9'd0, 16'h8000);
    send_compute(9'd0);
    send_write(OP_WRITE_WEIGHT, 9'd2, 9'd0, 16'h8000);
    send_write(OP_WRITE_BIAS, 9'd2, 9'd0, 16'h0000);
    send_compute(9'd2);

    // A zero channel count leaves only the bias.
    start_phase(0, 1'b1, 0, 0);
    send_compute(9'd1);
    send_compute(9'd0);
    send_compute(9'd511);

    start_phase(1, 1'b1, 0, 0);
    send_compute(9'd0);
    send_compute(9'd1);

    start_phase(3, 1'b1, 0, 0);
    holds_asked <= holds_asked + 1;
    run_random(100, 4, 1'b1);

    start_phase(8, 1'b0, 45, 0);
    run_random(100, 4, 1'b1);

    start_phase(1, 1'b1, 0, 45);
    run_random(100, 4, 1'b1);

    start_phase(20, 1'b0, 32, 32);
    run_random(100, 4, 1'b1);

    start_phase(MAX_IN, 1'b1, 32, 32);
    run_random(40, 1, 1'b1);

    // A count above the maximum is clamped, so the same row is reused.
    start_phase(1023, 1'b0, 0, 0);
    run_random(30, 1, 1'b0);

    start_phase(5, 1'b0, 32, 32);
    run_random(80, 4, 1'b1);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("** matrix_vector_bias_relu: PASSED **");
    end else begin
      $display("** matrix_vector_bias_relu: FAILED **");
    end
    $finish;
  end

endmodule
